>>> rtl/line_projection_extent_unit_macros.svh
// assertion helpers shared by the line projection extent modules
// each expects aclk and aresetn in the scope where it is used
`ifndef LINE_PROJECTION_EXTENT_UNIT_MACROS_SVH
`define LINE_PROJECTION_EXTENT_UNIT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define LPE_ASSERT_IMP(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (cond)) \
        else $error("lpe: same-cycle check failed");

// condition holds in the cycle after the trigger
`define LPE_ASSERT_NEXT(lbl, trig, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (cond)) \
        else $error("lpe: next-cycle check failed");

`endif

>>> rtl/lpe_pkg.sv
package lpe_pkg;

    localparam int REG_IDX_W = 3;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_BASE_X = 3'd0,
        REG_BASE_Y = 3'd1,
        REG_BASE_Z = 3'd2,
        REG_DIR_X  = 3'd3,
        REG_DIR_Y  = 3'd4,
        REG_DIR_Z  = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    typedef enum logic [3:0] {
        OP_NONE     = 4'd0,
        OP_LOAD_PT  = 4'd1,
        OP_T_MAC    = 4'd2,
        OP_N_MAC    = 4'd3,
        OP_T_UPD    = 4'd4,
        OP_P_SEL    = 4'd5,
        OP_P_MLO    = 4'd6,
        OP_P_MHI    = 4'd7,
        OP_P_DSTEP  = 4'd8,
        OP_P_FIN    = 4'd9,
        OP_OUT_LOAD = 4'd10
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        axis_t  axis;
        logic   use_end;
        logic   acc_clr;
    } dp_cmd_t;

    typedef struct packed {
        logic pt_last;
    } dp_status_t;

endpackage

>>> rtl/lpe_datapath.sv
module lpe_datapath #(
    parameter int COORD_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lpe_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_wdata,
    input  logic [COORD_BITS-1:0]         pt_x,
    input  logic [COORD_BITS-1:0]         pt_y,
    input  logic [COORD_BITS-1:0]         pt_z,
    input  logic                          pt_last,
    input  lpe_pkg::dp_cmd_t              cmd,
    output lpe_pkg::dp_status_t           status,
    output logic [9*COORD_BITS-1:0]       out_data
);
    import lpe_pkg::*;

    localparam int C   = COORD_BITS;
    localparam int MW  = C + 3;          // shared multiplier operand width
    localparam int PW  = 2 * MW;
    localparam int H   = C + 1;          // low split of |t|
    localparam int TMW = 2 * C + 3;      // |t| width
    localparam int SW  = 2 * C + 4;      // extent state width
    localparam int NW  = 3 * C + 3;      // numerator / quotient width
    localparam int RW  = 2 * C;          // norm and remainder width

    localparam logic signed [SW-1:0]  T_MAX  = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0]  T_MIN  = {1'b1, {(SW-1){1'b0}}};
    localparam logic signed [C+1:0]   SAT_HI = {3'b000, {(C-1){1'b1}}};
    localparam logic signed [C+1:0]   SAT_LO = {3'b111, {(C-1){1'b0}}};
    localparam logic [C:0]            Q_CLAMP = {1'b1, {C{1'b0}}};

    logic signed [C-1:0]  base_reg [3];
    logic signed [C-1:0]  dir_reg  [3];
    logic signed [C-1:0]  pt_reg   [3];
    logic                 last_reg;

    logic signed [MW-1:0] mul_a;
    logic signed [MW-1:0] mul_b;
    logic signed [C:0]    pt_diff;
    logic signed [PW-1:0] prod_reg;
    logic                 mac_pend_reg;
    logic                 mac_clr_reg;
    logic                 mac_shift_reg;
    logic                 mac_norm_reg;
    logic signed [NW-1:0] addend;
    logic signed [NW-1:0] acc_reg;
    logic [RW-1:0]        norm_reg;

    logic signed [SW-1:0] t_val;
    logic signed [SW-1:0] lowest_reg;
    logic signed [SW-1:0] highest_reg;
    logic signed [SW-1:0] t_sel;
    logic signed [SW-1:0] t_abs;
    logic [C-1:0]         d_abs;
    logic [TMW-1:0]       tmag_reg;
    logic                 tsign_reg;
    logic [C-1:0]         dmag_reg;
    logic                 dsign_reg;

    logic [RW:0]          rsh;
    logic [RW:0]          rdiff;
    logic                 div_ge;
    logic [RW-1:0]        rem_reg;
    logic [RW-1:0]        rem_next;

    logic                 q_big;
    logic                 q_rnd;
    logic [C:0]           q_clamped;
    logic signed [C+1:0]  off_pos;
    logic signed [C+1:0]  off_val;
    logic signed [C+1:0]  proj_sum;
    logic signed [C-1:0]  proj_val;
    logic signed [C-1:0]  res_reg [2][3];

    logic signed [C:0]    mid_sum [3];
    logic [9*C-1:0]       out_next;
    logic [9*C-1:0]       out_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                base_reg[i] <= '0;
                dir_reg[i]  <= '0;
            end
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_BASE_X: base_reg[0] <= cfg_wdata;
                REG_BASE_Y: base_reg[1] <= cfg_wdata;
                REG_BASE_Z: base_reg[2] <= cfg_wdata;
                REG_DIR_X:  dir_reg[0]  <= cfg_wdata;
                REG_DIR_Y:  dir_reg[1]  <= cfg_wdata;
                REG_DIR_Z:  dir_reg[2]  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_LOAD_PT) begin
            pt_reg[0] <= pt_x;
            pt_reg[1] <= pt_y;
            pt_reg[2] <= pt_z;
            last_reg  <= pt_last;
        end
    end

    assign status.pt_last = last_reg;

    // shared multiplier operand select
    assign pt_diff = (C+1)'(pt_reg[cmd.axis]) - (C+1)'(base_reg[cmd.axis]);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            OP_T_MAC: begin
                mul_a = MW'(pt_diff);
                mul_b = MW'(dir_reg[cmd.axis]);
            end
            OP_N_MAC: begin
                mul_a = MW'(dir_reg[cmd.axis]);
                mul_b = MW'(dir_reg[cmd.axis]);
            end
            OP_P_MLO: begin
                mul_a = MW'(dmag_reg);
                mul_b = MW'(tmag_reg[H-1:0]);
            end
            OP_P_MHI: begin
                mul_a = MW'(dmag_reg);
                mul_b = MW'(tmag_reg[TMW-1:H]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    // product lands in an accumulator in the cycle after the multiply
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_pend_reg <= 1'b0;
        end else begin
            mac_pend_reg <= (cmd.op == OP_T_MAC) || (cmd.op == OP_N_MAC) ||
                            (cmd.op == OP_P_MLO) || (cmd.op == OP_P_MHI);
        end
    end

    always_ff @(posedge aclk) begin
        mac_clr_reg   <= cmd.acc_clr;
        mac_shift_reg <= (cmd.op == OP_P_MHI);
        mac_norm_reg  <= (cmd.op == OP_N_MAC);
    end

    always_comb begin
        addend = NW'(prod_reg);
        if (mac_shift_reg) begin
            addend = addend <<< H;
        end
    end

    // restoring division step, quotient bits shift into the numerator
    assign rsh      = {rem_reg, acc_reg[NW-1]};
    assign rdiff    = rsh - {1'b0, norm_reg};
    assign div_ge   = rsh >= {1'b0, norm_reg};
    assign rem_next = div_ge ? rdiff[RW-1:0] : rsh[RW-1:0];

    always_ff @(posedge aclk) begin
        if (mac_pend_reg && !mac_norm_reg) begin
            acc_reg <= (mac_clr_reg ? '0 : acc_reg) + addend;
        end else if (cmd.op == OP_P_DSTEP) begin
            acc_reg <= {acc_reg[NW-2:0], div_ge};
        end
    end

    always_ff @(posedge aclk) begin
        if (mac_pend_reg && mac_norm_reg) begin
            norm_reg <= (mac_clr_reg ? '0 : norm_reg) + prod_reg[RW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_P_SEL) begin
            rem_reg <= '0;
        end else if (cmd.op == OP_P_DSTEP) begin
            rem_reg <= rem_next;
        end
    end

    // extent tracking
    assign t_val = acc_reg[SW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lowest_reg  <= T_MAX;
            highest_reg <= T_MIN;
        end else if (cmd.op == OP_T_UPD) begin
            if (t_val <= lowest_reg) begin
                lowest_reg <= t_val;
            end
            if (t_val >= highest_reg) begin
                highest_reg <= t_val;
            end
        end else if (cmd.op == OP_OUT_LOAD) begin
            lowest_reg  <= T_MAX;
            highest_reg <= T_MIN;
        end
    end

    // magnitudes and signs for one projection
    assign t_sel = cmd.use_end ? highest_reg : lowest_reg;
    assign t_abs = t_sel[SW-1] ? -t_sel : t_sel;
    assign d_abs = dir_reg[cmd.axis][C-1] ? C'(-dir_reg[cmd.axis]) : dir_reg[cmd.axis];

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_P_SEL) begin
            tmag_reg  <= t_abs[TMW-1:0];
            tsign_reg <= t_sel[SW-1];
            dmag_reg  <= d_abs;
            dsign_reg <= dir_reg[cmd.axis][C-1];
        end
    end

    // round half away from zero, clamp, add base, saturate
    assign q_big     = |acc_reg[NW-1:C];
    assign q_rnd     = {rem_reg, 1'b0} >= {1'b0, norm_reg};
    assign q_clamped = q_big ? Q_CLAMP : {1'b0, acc_reg[C-1:0]} + (C+1)'(q_rnd);
    assign off_pos   = signed'({1'b0, q_clamped});
    assign off_val   = (dsign_reg ^ tsign_reg) ? -off_pos : off_pos;
    assign proj_sum  = (C+2)'(base_reg[cmd.axis]) + off_val;

    always_comb begin
        if (norm_reg == '0) begin
            proj_val = base_reg[cmd.axis];
        end else if (proj_sum > SAT_HI) begin
            proj_val = SAT_HI[C-1:0];
        end else if (proj_sum < SAT_LO) begin
            proj_val = SAT_LO[C-1:0];
        end else begin
            proj_val = proj_sum[C-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_P_FIN) begin
            res_reg[cmd.use_end][cmd.axis] <= proj_val;
        end
    end

    // output stage: start, end, floor midpoint
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mid_sum[i] = (C+1)'(res_reg[0][i]) + (C+1)'(res_reg[1][i]);
            out_next[i*C +: C]     = res_reg[0][i];
            out_next[(3+i)*C +: C] = res_reg[1][i];
            out_next[(6+i)*C +: C] = mid_sum[i][C:1];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_OUT_LOAD) begin
            out_data_reg <= out_next;
        end
    end

    assign out_data = out_data_reg;

`include "line_projection_extent_unit_macros.svh"

    `LPE_ASSERT_NEXT(a_extent_cleared, cmd.op == OP_OUT_LOAD, (lowest_reg == T_MAX) && (highest_reg == T_MIN))

endmodule

>>> rtl/lpe_ctrl.sv
module lpe_ctrl #(
    parameter int COORD_BITS = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  lpe_pkg::dp_status_t status,
    output lpe_pkg::dp_cmd_t    cmd
);
    import lpe_pkg::*;

    localparam int NUM_W = 3 * COORD_BITS + 3;
    localparam int CNT_W = $clog2(NUM_W);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(NUM_W - 1);

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_TMUL  = 12'b000000000010,
        S_TWAIT = 12'b000000000100,
        S_TUPD  = 12'b000000001000,
        S_NMUL  = 12'b000000010000,
        S_PSEL  = 12'b000000100000,
        S_PLO   = 12'b000001000000,
        S_PHI   = 12'b000010000000,
        S_PWAIT = 12'b000100000000,
        S_PDIV  = 12'b001000000000,
        S_PFIN  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t           state_reg, state_next;
    axis_t            axis_reg, axis_next;
    logic             end_reg, end_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;
    logic             out_load;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next  = state_reg;
        axis_next   = axis_reg;
        end_next    = end_reg;
        cnt_next    = cnt_reg;
        out_load    = 1'b0;
        cmd.op      = OP_NONE;
        cmd.axis    = axis_reg;
        cmd.use_end = end_reg;
        cmd.acc_clr = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD_PT;
                    axis_next  = AXIS_X;
                    state_next = S_TMUL;
                end
            end
            S_TMUL: begin
                cmd.op      = OP_T_MAC;
                cmd.acc_clr = (axis_reg == AXIS_X);
                if (axis_reg == AXIS_Z) begin
                    axis_next  = AXIS_X;
                    state_next = S_TWAIT;
                end else begin
                    axis_next = axis_t'(axis_reg + 2'd1);
                end
            end
            S_TWAIT: state_next = S_TUPD;
            S_TUPD: begin
                cmd.op     = OP_T_UPD;
                state_next = status.pt_last ? S_NMUL : S_IDLE;
            end
            S_NMUL: begin
                cmd.op      = OP_N_MAC;
                cmd.acc_clr = (axis_reg == AXIS_X);
                if (axis_reg == AXIS_Z) begin
                    axis_next  = AXIS_X;
                    end_next   = 1'b0;
                    state_next = S_PSEL;
                end else begin
                    axis_next = axis_t'(axis_reg + 2'd1);
                end
            end
            S_PSEL: begin
                cmd.op     = OP_P_SEL;
                state_next = S_PLO;
            end
            S_PLO: begin
                cmd.op      = OP_P_MLO;
                cmd.acc_clr = 1'b1;
                state_next  = S_PHI;
            end
            S_PHI: begin
                cmd.op     = OP_P_MHI;
                state_next = S_PWAIT;
            end
            S_PWAIT: begin
                cnt_next   = '0;
                state_next = S_PDIV;
            end
            S_PDIV: begin
                cmd.op   = OP_P_DSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST) begin
                    state_next = S_PFIN;
                end
            end
            S_PFIN: begin
                cmd.op = OP_P_FIN;
                if (axis_reg == AXIS_Z) begin
                    axis_next = AXIS_X;
                    if (end_reg) begin
                        state_next = S_OUT;
                    end else begin
                        end_next   = 1'b1;
                        state_next = S_PSEL;
                    end
                end else begin
                    axis_next  = axis_t'(axis_reg + 2'd1);
                    state_next = S_PSEL;
                end
            end
            S_OUT: begin
                // hold the finished projections until the output register frees up
                if (out_free) begin
                    cmd.op     = OP_OUT_LOAD;
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            axis_reg      <= AXIS_X;
            end_reg       <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            end_reg       <= end_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;

`include "line_projection_extent_unit_macros.svh"

    `LPE_ASSERT_NEXT(a_out_hold, (state_reg == S_OUT) && out_valid_reg && !m_tready, state_reg == S_OUT)
    `LPE_ASSERT_NEXT(a_out_valid_set, out_load, out_valid_reg)
    `LPE_ASSERT_NEXT(a_div_done, (state_reg == S_PDIV) && (cnt_reg == DIV_LAST), state_reg == S_PFIN)
    `LPE_ASSERT_IMP(a_proj_axis, state_reg == S_PFIN, (axis_reg == AXIS_X) || (axis_reg == AXIS_Y) || (axis_reg == AXIS_Z))

endmodule

>>> rtl/line_projection_extent_unit.sv
// channel   | dir | group                    | contents
// ----------+-----+--------------------------+------------------------------------------
// points    | in  | s_tvalid/s_tready/s_tdata | px, py, pz; s_tlast marks last point
// extent    | out | m_tvalid/m_tready/m_tdata | start, end, midpoint of the projection
// config    | in  | cfg_wr_en/cfg_index       | base_x..z, dir_x..z, one per write
//
// a point runs through accept, three products on the shared multiplier, sum, compare
// the last point adds 3 norm products and 6 projections, each worked out by the
// bit-serial restoring divider, then a load of the output register
// a waiting result does not block accepting points; a new cloud end waits for m_tready
// aresetn is synchronous, active low; it clears the config to zero and the extent state
module line_projection_extent_unit #(
    parameter int COORD_BITS = 24
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [lpe_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]         cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // px, py, pz from the lowest bit up, zero padded to bytes
    input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, mid_x, mid_y, mid_z, lowest first
    output logic [((9*COORD_BITS+7)/8)*8-1:0] m_tdata
);
    import lpe_pkg::*;

    localparam int C     = COORD_BITS;
    localparam int OUT_W = ((9*C+7)/8)*8;

    dp_cmd_t        cmd;
    dp_status_t     status;
    logic [9*C-1:0] out_data;

    lpe_ctrl #(
        .COORD_BITS(COORD_BITS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    lpe_datapath #(
        .COORD_BITS(COORD_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .pt_x      (s_tdata[C-1:0]),
        .pt_y      (s_tdata[2*C-1:C]),
        .pt_z      (s_tdata[3*C-1:2*C]),
        .pt_last   (s_tlast),
        .cmd       (cmd),
        .status    (status),
        .out_data  (out_data)
    );

    assign m_tdata = OUT_W'(out_data);

endmodule

>>> test/line_projection_extent_unit_tb.sv
`timescale 1ns / 1ps

module line_projection_extent_unit_tb;
    import lpe_pkg::*;

    localparam int COORD_BITS = 24;
    localparam int NUM_FIELDS = 9;
    localparam int S_DATA_W = ((3 * COORD_BITS + 7) / 8) * 8;
    localparam int M_DATA_W = ((9 * COORD_BITS + 7) / 8) * 8;
    localparam int CLK_HALF = 6;
    localparam int RESET_CYCLES = 11;
    localparam int HOLD_LEN = 3000;
    localparam int SETTLE_CYCLES = 600;
    localparam int CYCLE_LIMIT = 5000000;
    localparam int RANDOM_ITEMS = 1700;
    localparam int NUM_PHASES = 4;
    localparam int ITEMS_PER_SETTING = 110;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    // start_x .. mid_z, field 0 in the lowest bits
    typedef logic [NUM_FIELDS-1:0][COORD_BITS-1:0] extent_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS - 1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS - 1){1'b0}}};
    localparam longint T_MAX = (longint'(1) <<< (2 * COORD_BITS + 3)) - 1;
    localparam longint T_MIN = -T_MAX - 1;

    // indexes past the last register, writes to them must be dropped
    localparam logic [REG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef enum logic {
        ROW_POINT,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [REG_IDX_W-1:0] idx;
        coord_t               x;    // write data on a register row
        coord_t               y;
        coord_t               z;
        logic                 is_last;
        logic                 pinned;
        extent_t              want;
    } stim_row_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [REG_IDX_W-1:0]  cfg_index = '0;
    logic [COORD_BITS-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  s_tlast = 1'b0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    // typed-in expectation that travels alongside the point it belongs to
    logic    row_pinned = 1'b0;
    extent_t row_want = '0;

    logic hold_start = 1'b0;
    int   hold_left = 0;
    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;

    coord_t  line_base [3];
    coord_t  line_dir [3];
    longint  t_low;
    longint  t_high;
    extent_t extent_q [$];
    int      mismatches = 0;
    coord_t  stim_base [3];

    string fld_label [NUM_FIELDS] = '{"start_x", "start_y", "start_z", "end_x", "end_y",
                                      "end_z", "mid_x", "mid_y", "mid_z"};

    always #(CLK_HALF) aclk = ~aclk;

    line_projection_extent_unit #(
        .COORD_BITS(COORD_BITS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_wr_en(cfg_wr_en),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    function automatic longint line_param(coord_t x, coord_t y, coord_t z);
        return (longint'(x) - longint'(line_base[0])) * longint'(line_dir[0])
             + (longint'(y) - longint'(line_base[1])) * longint'(line_dir[1])
             + (longint'(z) - longint'(line_base[2])) * longint'(line_dir[2]);
    endfunction

    // base + d * t / n, rounded half away from zero, then clamped
    function automatic coord_t project_axis(coord_t b, coord_t d, longint t, longint n);
        logic [63:0]         mag_d;
        logic [63:0]         mag_t;
        logic [127:0]        prod;
        logic [127:0]        quo;
        logic [127:0]        rem;
        logic [127:0]        n_wide;
        logic signed [127:0] off;
        logic signed [127:0] sum;
        if (n == 0)
            return b;
        mag_d = (d < 0) ? -longint'(d) : longint'(d);
        mag_t = (t < 0) ? -t : t;
        n_wide = {64'd0, n};
        prod = {64'd0, mag_d} * {64'd0, mag_t};
        quo = prod / n_wide;
        rem = prod % n_wide;
        if ((rem << 1) >= n_wide)
            quo = quo + 1;
        off = signed'(quo);
        if ((d < 0) != (t < 0))
            off = -off;
        sum = off + b;
        if (sum > COORD_MAX)
            return COORD_MAX;
        if (sum < COORD_MIN)
            return COORD_MIN;
        return sum[COORD_BITS-1:0];
    endfunction

    function automatic extent_t predict_extent();
        extent_t                r;
        longint                 n;
        logic [COORD_BITS:0]    pair;
        n = longint'(line_dir[0]) * line_dir[0] + longint'(line_dir[1]) * line_dir[1]
          + longint'(line_dir[2]) * line_dir[2];
        for (int a = 0; a < 3; a++) begin
            r[a] = project_axis(line_base[a], line_dir[a], t_low, n);
            r[3+a] = project_axis(line_base[a], line_dir[a], t_high, n);
            pair = {r[a][COORD_BITS-1], r[a]} + {r[3+a][COORD_BITS-1], r[3+a]};
            // dropping bit 0 of the sign-extended sum is the floor halving
            r[6+a] = pair[COORD_BITS:1];
        end
        return r;
    endfunction

    function automatic extent_t extent_of(coord_t sx, coord_t sy, coord_t sz,
                                          coord_t ex, coord_t ey, coord_t ez,
                                          coord_t mx, coord_t my, coord_t mz);
        return {mz, my, mx, ez, ey, ex, sz, sy, sx};
    endfunction

    function automatic stim_row_t point_row(coord_t x, coord_t y, coord_t z, logic is_last);
        stim_row_t r;
        r = '0;
        r.kind = ROW_POINT;
        r.x = x;
        r.y = y;
        r.z = z;
        r.is_last = is_last;
        return r;
    endfunction

    function automatic stim_row_t pinned_row(coord_t x, coord_t y, coord_t z, extent_t want);
        stim_row_t r;
        r = point_row(x, y, z, 1'b1);
        r.pinned = 1'b1;
        r.want = want;
        return r;
    endfunction

    function automatic stim_row_t write_row(logic [REG_IDX_W-1:0] idx, coord_t val);
        stim_row_t r;
        r = '0;
        r.kind = ROW_WRITE;
        r.idx = idx;
        r.x = val;
        return r;
    endfunction

    function automatic coord_t pick_coord(int spread);
        case ($urandom_range(9))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3, 4: return coord_t'(int'($urandom_range(2 * spread)) - spread);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic coord_t near_coord(coord_t b, int spread);
        if ($urandom_range(9) < 7)
            return coord_t'(b + (int'($urandom_range(2 * spread)) - spread));
        return pick_coord(spread);
    endfunction

    // checker and reference state, all sampled at the rising edge
    always @(posedge aclk) begin : scoreboard
        longint  t;
        extent_t got;
        extent_t want;
        if (!aresetn) begin
            for (int a = 0; a < 3; a++) begin
                line_base[a] = '0;
                line_dir[a] = '0;
            end
            t_low = T_MAX;
            t_high = T_MIN;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_BASE_X: line_base[0] = cfg_wdata;
                    REG_BASE_Y: line_base[1] = cfg_wdata;
                    REG_BASE_Z: line_base[2] = cfg_wdata;
                    REG_DIR_X:  line_dir[0] = cfg_wdata;
                    REG_DIR_Y:  line_dir[1] = cfg_wdata;
                    REG_DIR_Z:  line_dir[2] = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                t = line_param(s_tdata[COORD_BITS-1:0], s_tdata[2*COORD_BITS-1:COORD_BITS],
                               s_tdata[3*COORD_BITS-1:2*COORD_BITS]);
                if (t <= t_low)
                    t_low = t;
                if (t >= t_high)
                    t_high = t;
                if (s_tlast) begin
                    extent_q.insert(extent_q.size(), row_pinned ? row_want : predict_extent());
                    t_low = T_MAX;
                    t_high = T_MIN;
                end
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (extent_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("extent transfer with nothing expected: %h", got);
                end else begin
                    want = extent_q.pop_front();
                    for (int f = 0; f < NUM_FIELDS; f++) begin
                        if (got[f] !== want[f]) begin
                            mismatches++;
                            if (mismatches <= 10)
                                $display("%s mismatch: expected %0d, got %0d", fld_label[f],
                                         $signed(want[f]), $signed(got[f]));
                        end
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin : result_sink
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_left <= 0;
        end else if (hold_start) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_LEN;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("line_projection_extent_unit test failed");
        $finish;
    end

    task automatic send_point(coord_t x, coord_t y, coord_t z, logic is_last,
                              logic pinned, extent_t want);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {z, y, x};
        s_tlast <= is_last;
        row_pinned <= pinned;
        row_want <= want;
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender stays quiet until the block has nothing left to deliver
    task automatic drain_results();
        s_tvalid <= 1'b0;
        // let the scoreboard log the last transfer before the queue is checked
        @(posedge aclk);
        while (extent_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [REG_IDX_W-1:0] idx, coord_t val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
    endtask

    task automatic new_line_setting();
        coord_t d [3];
        int     mode;
        drain_results();
        mode = $urandom_range(7);
        for (int a = 0; a < 3; a++) begin
            case (mode)
                0: begin
                    stim_base[a] = pick_coord(4096);
                    d[a] = '0;
                end
                1: begin
                    stim_base[a] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                    d[a] = $urandom_range(1) ? COORD_MAX : COORD_MIN;
                end
                default: begin
                    stim_base[a] = pick_coord(1 << 16);
                    d[a] = pick_coord(1 << 12);
                end
            endcase
        end
        write_reg(REG_BASE_X, stim_base[0]);
        write_reg(REG_BASE_Y, stim_base[1]);
        write_reg(REG_BASE_Z, stim_base[2]);
        write_reg(REG_DIR_X, d[0]);
        write_reg(REG_DIR_Y, d[1]);
        write_reg(REG_DIR_Z, d[2]);
        if ($urandom_range(3) == 0)
            write_reg($urandom_range(1) ? REG_SPARE_7 : REG_SPARE_6, coord_t'($urandom));
        cfg_wr_en <= 1'b0;
    endtask

    initial begin : stimulus
        stim_row_t rows [$];
        logic      prev_write;
        int        send_pct_by_phase [NUM_PHASES] = '{0, 68, 0, 10};
        int        recv_pct_by_phase [NUM_PHASES] = '{0, 0, 68, 10};
        int        sent;
        int        next_setting;
        int        n_pts;
        int        spread;
        int        r;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // zero direction straight out of reset, base is still the origin
        rows.insert(rows.size(), pinned_row(COORD_MAX, COORD_MAX, COORD_MAX, '0));
        // unit x direction: a point projects onto its own x
        rows.insert(rows.size(), write_row(REG_DIR_X, 24'sd1024));
        rows.insert(rows.size(), point_row(COORD_MIN, 24'sd5, 24'sd7, 1'b0));
        rows.insert(rows.size(), pinned_row(COORD_MAX, -24'sd3, 24'sd2,
                                  extent_of(COORD_MIN, '0, '0, COORD_MAX, '0, '0,
                                            -24'sd1, '0, '0)));
        rows.insert(rows.size(), pinned_row(24'sd100, 24'sd200, 24'sd300,
                                  extent_of(24'sd100, '0, '0, 24'sd100, '0, '0,
                                            24'sd100, '0, '0)));
        // zero direction again, every output is the base point
        rows.insert(rows.size(), write_row(REG_BASE_X, COORD_MIN));
        rows.insert(rows.size(), write_row(REG_BASE_Y, COORD_MAX));
        rows.insert(rows.size(), write_row(REG_BASE_Z, 24'sd12345));
        rows.insert(rows.size(), write_row(REG_DIR_X, '0));
        rows.insert(rows.size(), write_row(REG_SPARE_6, 24'sd1024));
        rows.insert(rows.size(), point_row('0, '0, '0, 1'b0));
        rows.insert(rows.size(), pinned_row(COORD_MAX, COORD_MIN, -24'sd1,
                                  extent_of(COORD_MIN, COORD_MAX, 24'sd12345,
                                            COORD_MIN, COORD_MAX, 24'sd12345,
                                            COORD_MIN, COORD_MAX, 24'sd12345)));
        // base at the corners with a tiny direction, pushes outputs into saturation
        rows.insert(rows.size(), write_row(REG_SPARE_7, 24'sh5a5a5a));
        rows.insert(rows.size(), write_row(REG_BASE_X, COORD_MAX));
        rows.insert(rows.size(), write_row(REG_BASE_Y, COORD_MIN));
        rows.insert(rows.size(), write_row(REG_BASE_Z, '0));
        rows.insert(rows.size(), write_row(REG_DIR_X, 24'sd1));
        rows.insert(rows.size(), write_row(REG_DIR_Y, -24'sd1));
        rows.insert(rows.size(), point_row(COORD_MIN, COORD_MAX, '0, 1'b0));
        rows.insert(rows.size(), point_row(COORD_MAX, COORD_MIN, '0, 1'b1));
        // largest negative direction on every axis
        rows.insert(rows.size(), write_row(REG_BASE_X, '0));
        rows.insert(rows.size(), write_row(REG_BASE_Y, '0));
        rows.insert(rows.size(), write_row(REG_DIR_X, COORD_MIN));
        rows.insert(rows.size(), write_row(REG_DIR_Y, COORD_MIN));
        rows.insert(rows.size(), write_row(REG_DIR_Z, COORD_MIN));
        rows.insert(rows.size(), point_row(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0));
        rows.insert(rows.size(), point_row(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0));
        rows.insert(rows.size(), point_row('0, '0, '0, 1'b1));
        // repeated point, equal parameters
        rows.insert(rows.size(), point_row(24'sd5, 24'sd5, 24'sd5, 1'b0));
        rows.insert(rows.size(), point_row(24'sd5, 24'sd5, 24'sd5, 1'b1));
        // half-way offsets, rounding away from zero both ways
        rows.insert(rows.size(), write_row(REG_DIR_X, 24'sd1));
        rows.insert(rows.size(), write_row(REG_DIR_Y, 24'sd1));
        rows.insert(rows.size(), write_row(REG_DIR_Z, '0));
        rows.insert(rows.size(), point_row(24'sd1, '0, '0, 1'b1));
        rows.insert(rows.size(), point_row(-24'sd1, '0, '0, 1'b1));
        rows.insert(rows.size(), point_row(-24'sd1, -24'sd2, '0, 1'b0));
        rows.insert(rows.size(), point_row(24'sd3, '0, '0, 1'b1));
        // everything at the top of the range
        rows.insert(rows.size(), write_row(REG_BASE_X, COORD_MAX));
        rows.insert(rows.size(), write_row(REG_BASE_Y, COORD_MAX));
        rows.insert(rows.size(), write_row(REG_BASE_Z, COORD_MAX));
        rows.insert(rows.size(), write_row(REG_DIR_X, COORD_MAX));
        rows.insert(rows.size(), write_row(REG_DIR_Y, COORD_MAX));
        rows.insert(rows.size(), write_row(REG_DIR_Z, COORD_MAX));
        rows.insert(rows.size(), point_row(COORD_MIN, COORD_MAX, COORD_MIN, 1'b0));
        rows.insert(rows.size(), point_row(COORD_MAX, COORD_MIN, COORD_MAX, 1'b1));

        prev_write = 1'b0;
        foreach (rows[i]) begin
            if (rows[i].kind == ROW_WRITE) begin
                if (!prev_write)
                    drain_results();
                write_reg(rows[i].idx, rows[i].x);
            end else begin
                if (prev_write)
                    cfg_wr_en <= 1'b0;
                send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].is_last,
                           rows[i].pinned, rows[i].want);
            end
            prev_write = (rows[i].kind == ROW_WRITE);
        end

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            new_line_setting();
            send_idle_pct = send_pct_by_phase[phase];
            recv_stall_pct = recv_pct_by_phase[phase];
            if (phase == 0) begin
                // long receiver hold-off while clouds keep coming, fills the block
                hold_start <= 1'b1;
                @(posedge aclk);
                hold_start <= 1'b0;
            end
            sent = 0;
            next_setting = ITEMS_PER_SETTING;
            while (sent < RANDOM_ITEMS / NUM_PHASES) begin
                if (sent >= next_setting) begin
                    new_line_setting();
                    next_setting = sent + ITEMS_PER_SETTING;
                end
                r = $urandom_range(99);
                if (r < 70)
                    n_pts = $urandom_range(8, 1);
                else if (r < 95)
                    n_pts = $urandom_range(24, 9);
                else
                    n_pts = $urandom_range(60, 25);
                case ($urandom_range(2))
                    0: spread = 64;
                    1: spread = 4096;
                    default: spread = 1 << 20;
                endcase
                for (int k = 0; k < n_pts; k++) begin
                    send_point(near_coord(stim_base[0], spread), near_coord(stim_base[1], spread),
                               near_coord(stim_base[2], spread), k == n_pts - 1, 1'b0, '0);
                    sent++;
                end
            end
        end

        drain_results();
        if (mismatches == 0)
            $display("line_projection_extent_unit test passed");
        else
            $display("line_projection_extent_unit test failed");
        $finish;
    end

endmodule
